// ----- design/oukq_pkg.sv -----
// ---------------------------------------------------------------------------
// oukq_pkg
// Shared types for the ordered unique key queue: the request and response
// payloads, the sequencer states and the control word that goes to the cells.
// ---------------------------------------------------------------------------
package oukq_pkg;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] key;
  } req_t;

  typedef struct packed {
    logic        was_present;
    logic        changed;
    logic        overflow;
    logic [4:0]  entry_count;
    logic [31:0] oldest_key;
    logic        oldest_valid;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD,
    ST_RSP
  } state_e;

  typedef struct packed {
    logic cmp_en;
    logic rem_en;
    logic app_en;
  } cell_ctrl_t;

endpackage

// ----- design/ordered_unique_key_queue.sv -----
// ---------------------------------------------------------------------------
// ordered_unique_key_queue
// Insertion-ordered set of up to DEPTH distinct 32-bit keys held in a chain
// of slot cells. Each request passes through capture, parallel compare in
// every cell, update (append at the tail or remove and shift the later cells
// down by one), and response. One request is in flight at a time; the next
// request is taken once the previous response sits in the output register,
// and the response stage waits while the output register is still stalled.
// ---------------------------------------------------------------------------
module ordered_unique_key_queue #(
  parameter int DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  oukq_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output oukq_pkg::rsp_t out_data_o
);
  import oukq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  state_e      state_q, state_d;
  req_t        req_q;
  logic [CW-1:0] count_q, count_d;
  logic        present_q, changed_q, overflow_q;
  logic        out_valid_q;
  rsp_t        out_q;

  cell_ctrl_t  ctrl;
  logic [DEPTH-1:0]  match;
  logic [DEPTH-1:0]  load;
  logic [DEPTH-1:0]  active;
  logic [DEPTH:0]    shift;
  logic [31:0]       keys [DEPTH];
  logic              present;
  logic              do_app, do_rem;
  logic              in_acc, out_acc;
  logic [CW+4:0]     count_ext;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_q && !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  assign present = |match;
  assign do_app  = (req_q.op == OP_APPEND) && !present && (count_q < CW'(DEPTH));
  assign do_rem  = (req_q.op == OP_REMOVE) && present;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ctrl.cmp_en = 1'b0;
    ctrl.rem_en = 1'b0;
    ctrl.app_en = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_CMP;
      end
      ST_CMP: begin
        ctrl.cmp_en = 1'b1;
        state_d     = ST_UPD;
      end
      ST_UPD: begin
        ctrl.rem_en = do_rem;
        ctrl.app_en = do_app;
        if (do_app) count_d = count_q + CW'(1);
        else if (do_rem) count_d = count_q - CW'(1);
        state_d = ST_RSP;
      end
      ST_RSP: begin
        if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (state_q == ST_RSP && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign count_ext = {5'b0, count_q};

  always_ff @(posedge clk_i) begin
    if (in_acc) req_q <= in_data_i;
    if (state_q == ST_UPD) begin
      present_q  <= present;
      changed_q  <= do_app || do_rem;
      overflow_q <= (req_q.op == OP_APPEND) && !present && !do_app;
    end
    if (state_q == ST_RSP && (!out_valid_q || !out_stall_i)) begin
      out_q.was_present  <= present_q;
      out_q.changed      <= changed_q;
      out_q.overflow     <= overflow_q;
      out_q.entry_count  <= count_ext[4:0];
      out_q.oldest_key   <= (count_q != '0) ? keys[0] : 32'd0;
      out_q.oldest_valid <= (count_q != '0);
    end
  end

  assign shift[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign active[i] = (count_q > CW'(i));
    assign load[i]   = (count_q == CW'(i));
    oukq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .req_key_i  (req_q.key),
      .active_i   (active[i]),
      .load_i     (load[i]),
      .next_key_i ((i == DEPTH - 1) ? keys[i] : keys[(i + 1) % DEPTH]),
      .shift_i    (shift[i]),
      .shift_o    (shift[i+1]),
      .match_o    (match[i]),
      .key_o      (keys[i])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- design/oukq_cell.sv -----
// ---------------------------------------------------------------------------
// oukq_cell
// One slot of the key chain. Compares its key against the request, and on
// update either takes the key of its right neighbor (gap closing on remove)
// or loads the request key (append at the tail).
// ---------------------------------------------------------------------------
module oukq_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  oukq_pkg::cell_ctrl_t  ctrl_i,
  input  logic [31:0]           req_key_i,
  input  logic                  active_i,
  input  logic                  load_i,
  input  logic [31:0]           next_key_i,
  input  logic                  shift_i,
  output logic                  shift_o,
  output logic                  match_o,
  output logic [31:0]           key_o
);
  import oukq_pkg::*;

  logic [31:0] key_q;
  logic        match_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.cmp_en) begin
      match_q <= active_i && (key_q == req_key_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rem_en && shift_o) begin
      key_q <= next_key_i;
    end else if (ctrl_i.app_en && load_i) begin
      key_q <= req_key_i;
    end
  end

  // set from the matching slot rightward
  assign shift_o = shift_i | match_q;
  assign match_o = match_q;
  assign key_o   = key_q;

endmodule
